// ----- design/rc4ks_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4ks_pkg
// Shared types and constants for the RC4 keystream/XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4ks_pkg;

   localparam int KEY_REG_BYTES = 5;
   localparam int KEY_W         = 8 * KEY_REG_BYTES;
   localparam int SYM_W         = 8;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   typedef struct packed {
      logic             action;
      logic [SYM_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] out_byte;
      logic [SYM_W-1:0] keystream_byte;
   } rsp_type;

   // one access bundle per cycle toward the permutation memory
   typedef struct packed {
      logic             clear;
      logic             wr_en;
      logic [SYM_W-1:0] wr_addr;
      logic [SYM_W-1:0] wr_data;
      logic [SYM_W-1:0] rd_addr;
   } perm_req_type;

endpackage

`default_nettype wire

// ----- design/rc4ks_perm_mem.sv -----
// ----------------------------------------------------------------------------
// rc4ks_perm_mem
// 256 x 8 permutation memory, one write and one registered read per cycle.
// Per-entry valid bits make a never-written entry read as its own address,
// so reset and a key-schedule start restore the identity by clearing them.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4ks_perm_mem
   import rc4ks_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire perm_req_type     mem_req,
   output logic [SYM_W-1:0]      rd_data
);

   localparam int DEPTH = 1 << SYM_W;

   logic [SYM_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      if (valid_ff[mem_req.rd_addr]) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end else begin
         rd_data_ff <= mem_req.rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || mem_req.clear) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/rc4ks_seq.sv -----
// ----------------------------------------------------------------------------
// rc4ks_seq
// Sequencer: runs the key schedule and the keystream step as read/modify/
// write passes over the permutation memory, holding i, j and the key index.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4ks_seq
   import rc4ks_pkg::*;
#(
   parameter int KEY_BYTES = 5
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   input  wire logic [KEY_W-1:0] key,
   input  wire logic             rsp_free,
   output logic                  ks_valid,
   output rsp_type               ks_data,
   output perm_req_type          mem_req,
   input  wire logic [SYM_W-1:0] rd_data
);

   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);
   localparam logic [SYM_W-1:0]  LAST_STEP = '1;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_RDI  = 8'b0000_0010,
      ST_RDJ  = 8'b0000_0100,
      ST_WRJ  = 8'b0000_1000,
      ST_KRDS = 8'b0001_0000,
      ST_KRDA = 8'b0010_0000,
      ST_KWRS = 8'b0100_0000,
      ST_KWRA = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [SYM_W-1:0]  i_ff, i_in;
   logic [SYM_W-1:0]  j_ff, j_in;
   logic [SYM_W-1:0]  si_ff, si_in;
   logic [SYM_W-1:0]  sj_ff, sj_in;
   logic [SYM_W-1:0]  t_ff, t_in;
   logic [SYM_W-1:0]  data_ff, data_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [SYM_W-1:0]  key_byte;
   logic [SYM_W-1:0]  ks;

   // key bytes past the register read as zero
   always_comb begin
      key_byte = '0;
      for (int n = 0; n < KEY_REG_BYTES; n++) begin
         if (int'(kidx_ff) == n) begin
            key_byte = key[n*SYM_W +: SYM_W];
         end
      end
   end

   // the swap's two writes are not yet all visible to the read of S[t]
   always_comb begin
      if (t_ff == j_ff) begin
         ks = si_ff;
      end else if (t_ff == i_ff) begin
         ks = sj_ff;
      end else begin
         ks = rd_data;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      si_in     = si_ff;
      sj_in     = sj_ff;
      t_in      = t_ff;
      data_in   = data_ff;
      kidx_in   = kidx_ff;
      req_ready = 1'b0;
      ks_valid  = 1'b0;
      mem_req   = '{clear: 1'b0, wr_en: 1'b0, wr_addr: '0, wr_data: '0, rd_addr: '0};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.action == ACT_BYTE) begin
                  i_in            = i_ff + 1'b1;
                  data_in         = req_data.data_byte;
                  mem_req.rd_addr = i_in;
                  state_in        = ST_RDI;
               end else begin
                  mem_req.clear = 1'b1;
                  i_in          = '0;
                  j_in          = '0;
                  kidx_in       = '0;
                  state_in      = ST_KRDS;
               end
            end
         end
         ST_RDI: begin
            si_in           = rd_data;
            j_in            = j_ff + rd_data;
            mem_req.rd_addr = j_in;
            state_in        = ST_RDJ;
         end
         ST_RDJ: begin
            sj_in           = rd_data;
            t_in            = si_ff + rd_data;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff;
            mem_req.wr_data = rd_data;
            mem_req.rd_addr = t_in;
            state_in        = ST_WRJ;
         end
         ST_WRJ: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = si_ff;
            mem_req.rd_addr = t_ff;
            if (rsp_free) begin
               ks_valid = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_KRDS: begin
            mem_req.rd_addr = i_ff;
            state_in        = ST_KRDA;
         end
         ST_KRDA: begin
            si_in           = rd_data;
            j_in            = j_ff + rd_data + key_byte;
            mem_req.rd_addr = j_in;
            state_in        = ST_KWRS;
         end
         ST_KWRS: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = i_ff;
            mem_req.wr_data = rd_data;
            state_in        = ST_KWRA;
         end
         ST_KWRA: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = j_ff;
            mem_req.wr_data = si_ff;
            kidx_in         = (kidx_ff == KIDX_LAST) ? '0 : kidx_ff + 1'b1;
            if (i_ff == LAST_STEP) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_KRDS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         kidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         kidx_ff  <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      data_ff <= data_in;
   end

   assign ks_data.out_byte       = data_ff ^ ks;
   assign ks_data.keystream_byte = ks;

endmodule

`default_nettype wire

// ----- design/rc4_keystream_xor.sv -----
// ----------------------------------------------------------------------------
// rc4_keystream_xor
// RC4 keystream generator with XOR, one data byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   csr_wr_en/csr_wr_data load the 40-bit key; it is used at the next start.
//   req channel (valid/ready): action start rebuilds the permutation from the
//   key and gives no response; action byte runs one generator step.
//   rsp channel (valid/ready): out_byte = data_byte ^ keystream_byte.
// Sequencing:
//   a byte transfer uses the permutation memory in turn (read S[i],
//   read S[j], write S[i] with read S[i]+S[j], write S[j]); the response is
//   registered and becomes valid as the sequencer returns to idle, when the
//   next request can be taken, so only one byte is in flight at a time.
//   a start runs 256 schedule steps, each reading and writing S[i] and S[j];
//   no request is taken until the last schedule step has written.
// Reset: identity permutation, i = j = 0, key zero, response register empty.
// A stalled response register holds its transfer; a new request is still
// taken, and its step waits in the last phase until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_keystream_xor
   import rc4ks_pkg::*;
#(
   parameter int KEY_BYTES = 5
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [KEY_W-1:0] csr_wr_data
);

   logic [KEY_W-1:0] key_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             rsp_free;
   logic             ks_valid;
   rsp_type          ks_data;
   perm_req_type     mem_req;
   logic [SYM_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= ks_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ks_valid) begin
         rsp_data_ff <= ks_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rc4ks_seq #(
      .KEY_BYTES (KEY_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .key       (key_ff),
      .rsp_free  (rsp_free),
      .ks_valid  (ks_valid),
      .ks_data   (ks_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   rc4ks_perm_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // one item in flight: the sequencer is busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a step was still running");

   // a step result is only produced when the response register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ks_valid |-> rsp_free)
      else $error("step result would overwrite a pending response");

   // a response appears only out of a running step
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a step in progress");

endmodule

`default_nettype wire

// ----- verif/tb_rc4_keystream_xor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc4_keystream_xor
// Self-checking bench for the RC4 keystream/XOR block. A class keeps its own
// copy of the permutation table, indices and key, and it predicts each
// keystream byte as the request transfers. The response stream is compared
// in order. Keys are loaded between phases, only while the block is quiet.
// ----------------------------------------------------------------------------

module tb_rc4_keystream_xor
   import rc4ks_pkg::*;
();

   localparam int KEY_BYTES     = 5;
   localparam int SETTLE_CYCLES = 1100;  // outlasts the busy time of a start
   localparam int PHASE_ITEMS   = 175;

   class rc4_keystream_tracker;
      logic [SYM_W-1:0] perm [256];
      logic [SYM_W-1:0] idx_i;
      logic [SYM_W-1:0] idx_j;
      logic [KEY_W-1:0] key;
      rsp_type          pending_bytes [$];
      int unsigned      mismatches;
      int unsigned      byte_count;
      int unsigned      schedule_count;

      function new();
         fill_identity();
         idx_i          = '0;
         idx_j          = '0;
         key            = '0;
         mismatches     = 0;
         byte_count     = 0;
         schedule_count = 0;
      endfunction

      function void fill_identity();
         for (int n = 0; n < 256; n++) perm[n] = SYM_W'(n);
      endfunction

      function logic [SYM_W-1:0] key_byte(int unsigned s);
         int unsigned pos;
         pos = s % KEY_BYTES;
         // key bytes past the register width read as zero
         if (pos >= KEY_REG_BYTES) return '0;
         return key[8*pos +: 8];
      endfunction

      function void run_schedule();
         logic [SYM_W-1:0] acc;
         logic [SYM_W-1:0] t;
         fill_identity();
         acc = '0;
         for (int s = 0; s < 256; s++) begin
            acc       = acc + perm[s] + key_byte(s);
            t         = perm[s];
            perm[s]   = perm[acc];
            perm[acc] = t;
         end
         idx_i = '0;
         idx_j = '0;
         schedule_count++;
      endfunction

      function void note_request(req_type r);
         logic [SYM_W-1:0] t;
         logic [SYM_W-1:0] sum;
         rsp_type          e;
         if (r.action == ACT_START) begin
            run_schedule();
            return;
         end
         idx_i       = idx_i + 1'b1;
         idx_j       = idx_j + perm[idx_i];
         t           = perm[idx_i];
         perm[idx_i] = perm[idx_j];
         perm[idx_j] = t;
         sum              = perm[idx_i] + perm[idx_j];
         e.keystream_byte = perm[sum];
         e.out_byte       = r.data_byte ^ e.keystream_byte;
         pending_bytes.push_back(e);
         byte_count++;
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (pending_bytes.size() == 0) begin
            $error("unexpected response: out_byte %02h keystream_byte %02h",
                   r.out_byte, r.keystream_byte);
            mismatches++;
            return;
         end
         e = pending_bytes.pop_front();
         if (r.out_byte !== e.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", e.out_byte, r.out_byte);
            mismatches++;
         end
         if (r.keystream_byte !== e.keystream_byte) begin
            $error("keystream_byte: expected %02h, actual %02h",
                   e.keystream_byte, r.keystream_byte);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return pending_bytes.size();
      endfunction
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [KEY_W-1:0] csr_wr_data = '0;

   bit          offering  = 1'b0;
   bit          send_idle = 1'b1;
   bit          rsp_idle  = 1'b1;
   int unsigned rsp_hold  = 0;
   int unsigned key_loads = 0;

   rc4_keystream_tracker ks_track = new();

   always #2 clock = ~clock;

   rc4_keystream_xor #(.KEY_BYTES(KEY_BYTES)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // transfers are taken from the values the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) ks_track.note_request(req_data);
         if (rsp_valid && rsp_ready) ks_track.check_response(rsp_data);
      end
   end

   // response side: random stalls, a long hold-off when asked, or always ready
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (rsp_idle) begin
         rsp_ready <= ($urandom_range(99) >= 23);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_req(logic act, logic [SYM_W-1:0] d);
      req_type r;
      r.action    = act;
      r.data_byte = d;
      return r;
   endfunction

   task automatic stop_offering();
      if (offering) begin
         req_valid <= 1'b0;
         offering   = 1'b0;
      end
   endtask

   // returns at the edge where the request transfers
   task automatic offer(input req_type r);
      int unsigned gap;
      gap = 0;
      if (send_idle) while ($urandom_range(99) < 23) gap++;
      if (gap > 0) begin
         stop_offering();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      offering   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_results_done();
      stop_offering();
      do @(posedge clock); while (ks_track.pending() != 0);
   endtask

   task automatic load_key(input logic [KEY_W-1:0] k);
      wait_results_done();
      // a start may still be scheduling without any response owed
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ks_track.key = k;
      key_loads++;
   endtask

   task automatic run_items(input int unsigned n);
      for (int unsigned m = 0; m < n; m++) begin
         if ($urandom_range(39) == 0) offer(make_req(ACT_START, SYM_W'($urandom)));
         else offer(make_req(ACT_BYTE, SYM_W'($urandom)));
      end
   endtask

   task automatic random_key_phase(input logic [KEY_W-1:0] k);
      load_key(k);
      if ($urandom_range(3) != 0) offer(make_req(ACT_START, SYM_W'($urandom)));
      run_items(PHASE_ITEMS);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // generator running on the reset state, no schedule yet
      offer(make_req(ACT_BYTE, 8'h00));
      offer(make_req(ACT_BYTE, 8'hFF));
      offer(make_req(ACT_BYTE, 8'h55));
      offer(make_req(ACT_BYTE, 8'hAA));
      // start with a zero key; its data byte is ignored
      offer(make_req(ACT_START, 8'hFF));
      offer(make_req(ACT_BYTE, 8'h00));
      offer(make_req(ACT_BYTE, 8'hFF));
      // new key is not used until the next start
      load_key({KEY_W{1'b1}});
      offer(make_req(ACT_BYTE, 8'h0F));
      offer(make_req(ACT_BYTE, 8'hF0));
      offer(make_req(ACT_START, 8'h00));
      offer(make_req(ACT_BYTE, 8'h01));
      offer(make_req(ACT_BYTE, 8'h80));
      load_key(40'h01_0203_0405);
      offer(make_req(ACT_START, 8'h5A));
      offer(make_req(ACT_BYTE, 8'h12));
      offer(make_req(ACT_BYTE, 8'h34));
      // a second start under the same key, then a start after a key load
      offer(make_req(ACT_START, 8'h00));
      offer(make_req(ACT_BYTE, 8'hFF));
      load_key('0);
      offer(make_req(ACT_START, 8'hA5));
      offer(make_req(ACT_BYTE, 8'hC3));

      random_key_phase(KEY_W'({$urandom, $urandom}));

      // long response hold-off while requests keep coming
      load_key({KEY_W{1'b1}});
      offer(make_req(ACT_START, 8'h00));
      run_items(90);
      rsp_hold <= 400;
      run_items(85);

      // full rate on both sides
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      random_key_phase('0);
      send_idle = 1'b1;
      rsp_idle  = 1'b1;

      // sender waits for every response mid-phase
      load_key(KEY_W'({$urandom, $urandom}));
      offer(make_req(ACT_START, 8'h00));
      run_items(85);
      wait_results_done();
      run_items(90);

      random_key_phase(40'h80_0000_0001);
      for (int p = 0; p < 3; p++) random_key_phase(KEY_W'({$urandom, $urandom}));

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d keystream bytes over %0d key schedules and %0d key loads",
               ks_track.byte_count, ks_track.schedule_count, key_loads);
      $display("with random gaps on both sides, a long response hold-off and a drain pause");
      if (ks_track.mismatches == 0) begin
         $display("tb_rc4_keystream_xor: PASS");
      end else begin
         $display("tb_rc4_keystream_xor: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d responses outstanding", ks_track.pending());
      $display("tb_rc4_keystream_xor: FAIL");
      $finish;
   end

endmodule
